// ----- rtl/hybrid_load_value_predictor_assert.svh -----
// Assertion macros for the hybrid load value predictor.
`ifndef HYBRID_LOAD_VALUE_PREDICTOR_ASSERT_SVH
`define HYBRID_LOAD_VALUE_PREDICTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HLVP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HLVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hlvp_pkg.sv -----
// Shared constants, types and functions of the hybrid load value predictor.
package hlvp_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int LIMIT_W       = 9;
    localparam int PAT_ENTRIES   = 4096;
    localparam int PAT_W         = $clog2(PAT_ENTRIES);
    localparam int CONF_W        = 4;
    localparam logic [CONF_W-1:0] CONF_MAX = 4'd15;

    localparam logic [1:0] REG_TABLE_LIMIT = 2'd0;
    localparam logic [1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_PENALTY     = 2'd2;

    localparam logic [1:0] SRC_CONTEXT = 2'd0;
    localparam logic [1:0] SRC_FORWARD = 2'd1;
    localparam logic [1:0] SRC_STRIDE  = 2'd2;

    // history row: tag, four values, write pointer
    localparam int HROW_W = 64 + 4 * 64 + 2;

    typedef struct packed {
        logic take;
        logic clear_en;
        logic scan_en;
        logic hash_en;
        logic load_wr;
        logic store_wr;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic is_store;
        logic out_busy;
    } status_t;

    function automatic logic [15:0] fold16(input logic [63:0] v);
        return v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48];
    endfunction

    // oldest value first, shifted by 6, 4, 2, 0
    function automatic logic [PAT_W-1:0] ctx_hash(input logic [255:0] vals,
                                                  input logic [1:0] ptr);
        logic [15:0] h;
        logic [1:0]  idx;
        logic [21:0] sh;
        h = '0;
        for (int i = 0; i < 4; i++)
        begin
            idx = ptr + 2'(i);
            sh  = {6'b0, fold16(vals[{idx, 6'b0} +: 64])} << (2 * (3 - i));
            h   = h ^ sh[15:0];
        end
        return h[PAT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] next_head(input logic [IDX_W-1:0] head,
                                                   input logic [LIMIT_W-1:0] lim);
        logic [LIMIT_W-1:0] n;
        n = {1'b0, head} + 9'd1;
        return (n == lim) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [CONF_W-1:0] conf_step(input logic [CONF_W-1:0] c,
                                                    input logic hit,
                                                    input logic [CONF_W-1:0] pen);
        if (hit)
            return (c < CONF_MAX) ? c + 4'd1 : c;
        return (c > pen) ? c - pen : '0;
    endfunction

endpackage

// ----- rtl/hlvp_ctrl.sv -----
// Sequencer of the hybrid load value predictor.
module hlvp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  hlvp_pkg::status_t st,
    output hlvp_pkg::cmd_t   cmd,
    output logic             s_tready
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_HASH   = 7'b0001000,
        S_PAT    = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_STORE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (st.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (st.scan_done)
                    state_next = st.is_store ? S_STORE : S_HASH;
            end
            S_HASH:
            begin
                cmd.hash_en = 1'b1;
                state_next  = S_PAT;
            end
            S_PAT:
            begin
                if (!st.out_busy)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_STORE:
            begin
                cmd.store_wr = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

endmodule

// ----- rtl/hlvp_datapath.sv -----
// Tables, tag scan, choice and training datapath of the predictor.
module hlvp_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  hlvp_pkg::cmd_t   cmd,
    output hlvp_pkg::status_t st,
    input  logic [191:0]     s_tdata,
    input  logic [0:0]       s_tuser,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_data,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [63:0]      m_tdata,
    output logic [2:0]       m_tuser
);

    localparam int IW = hlvp_pkg::IDX_W;
    localparam int HW = hlvp_pkg::HROW_W;
    localparam int PW = hlvp_pkg::PAT_W;
    localparam int CW = hlvp_pkg::CONF_W;

    // configuration
    logic [8:0]    limit_reg;
    logic [CW-1:0] thr_reg, pen_reg;
    logic [8:0]    lim;

    // latched request
    logic [63:0] pc_reg, addr_reg, val_reg;
    logic        store_reg;

    // scan
    logic [IW:0]   cnt_reg;
    logic          cmp_v_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          hv_q_reg, fv_q_reg, sv_q_reg;

    // memories and read data
    logic [HW-1:0]  hist_mem [hlvp_pkg::TABLE_ENTRIES];
    logic [127:0]   fwd_mem  [hlvp_pkg::TABLE_ENTRIES];
    logic [191:0]   str_mem  [hlvp_pkg::TABLE_ENTRIES];
    logic [63:0]    pat_mem  [hlvp_pkg::PAT_ENTRIES];
    logic [HW-1:0]  hist_rd_reg;
    logic [127:0]   fwd_rd_reg;
    logic [191:0]   str_rd_reg;
    logic [63:0]    pat_rd_reg;

    logic [hlvp_pkg::TABLE_ENTRIES-1:0] hvalid_reg, fvalid_reg, svalid_reg;
    logic [IW-1:0] hhead_reg, fhead_reg, shead_reg;

    // captured hits
    logic          hhit_reg, fhit_reg, shit_reg;
    logic [IW-1:0] hidx_reg, fidx_reg, sidx_reg;
    logic [HW-1:0] hrow_reg;
    logic [63:0]   fval_reg, slast_reg, sdelta_reg;

    logic [PW-1:0] hash_reg;
    logic [63:0]   psum_reg;
    logic [PW-1:0] clr_reg;

    logic [CW-1:0] cc_reg, cf_reg, cs_reg;

    logic          out_valid_reg;
    logic [63:0]   out_pred_reg;
    logic [1:0]    out_src_reg;
    logic          out_ok_reg;

    // decide-stage logic
    logic [63:0]   p_ctx, p_fwd, p_str, pred;
    logic [1:0]    src;
    logic [1:0]    hptr;
    logic [HW-1:0] hrow_new;
    logic [IW-1:0] hslot, fslot, sslot;
    logic          fwd_we;
    logic [IW-1:0] scan_addr;

    assign lim = (limit_reg == 9'd0) ? 9'd1 :
                 (limit_reg > 9'(hlvp_pkg::TABLE_ENTRIES)) ?
                 9'(hlvp_pkg::TABLE_ENTRIES) : limit_reg;

    assign scan_addr = cnt_reg[IW-1:0];

    assign st.clear_done = (clr_reg == {PW{1'b1}});
    assign st.scan_done  = cnt_reg[IW];
    assign st.is_store   = store_reg;
    assign st.out_busy   = out_valid_reg && !m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 9'd256;
            thr_reg   <= 4'd3;
            pen_reg   <= 4'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hlvp_pkg::REG_TABLE_LIMIT: limit_reg <= cfg_data;
                hlvp_pkg::REG_THRESHOLD:   thr_reg   <= cfg_data[CW-1:0];
                hlvp_pkg::REG_PENALTY:     pen_reg   <= cfg_data[CW-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pc_reg    <= s_tdata[63:0];
            addr_reg  <= s_tdata[127:64];
            val_reg   <= s_tdata[191:128];
            store_reg <= s_tuser[0];
        end
    end

    // clearing pass over the pattern table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_en && !st.clear_done)
            clr_reg <= clr_reg + 1'b1;
    end

    // scan counter: issue one slot a cycle, compare it in the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            cmp_v_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            cnt_reg   <= '0;
            cmp_v_reg <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            cmp_v_reg <= !cnt_reg[IW];
            if (!cnt_reg[IW])
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_addr;
        hv_q_reg    <= hvalid_reg[scan_addr];
        fv_q_reg    <= fvalid_reg[scan_addr];
        sv_q_reg    <= svalid_reg[scan_addr];
    end

    // hit capture, first matching slot wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hhit_reg <= 1'b0;
            fhit_reg <= 1'b0;
            shit_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            hhit_reg <= 1'b0;
            fhit_reg <= 1'b0;
            shit_reg <= 1'b0;
        end
        else if (cmd.scan_en && cmp_v_reg)
        begin
            if (!hhit_reg && hv_q_reg && hist_rd_reg[63:0] == pc_reg)
                hhit_reg <= 1'b1;
            if (!fhit_reg && fv_q_reg && fwd_rd_reg[63:0] == addr_reg)
                fhit_reg <= 1'b1;
            if (!shit_reg && sv_q_reg && str_rd_reg[63:0] == pc_reg)
                shit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en && cmp_v_reg)
        begin
            if (!hhit_reg && hv_q_reg && hist_rd_reg[63:0] == pc_reg)
            begin
                hidx_reg <= cmp_idx_reg;
                hrow_reg <= hist_rd_reg;
            end
            if (!fhit_reg && fv_q_reg && fwd_rd_reg[63:0] == addr_reg)
            begin
                fidx_reg <= cmp_idx_reg;
                fval_reg <= fwd_rd_reg[127:64];
            end
            if (!shit_reg && sv_q_reg && str_rd_reg[63:0] == pc_reg)
            begin
                sidx_reg   <= cmp_idx_reg;
                slast_reg  <= str_rd_reg[127:64];
                sdelta_reg <= str_rd_reg[191:128];
            end
        end
        if (cmd.hash_en)
        begin
            hash_reg <= hhit_reg ? hlvp_pkg::ctx_hash(hrow_reg[319:64], hrow_reg[321:320])
                                 : '0;
            psum_reg <= slast_reg + sdelta_reg;
        end
    end

    // decide-stage predictions and writes
    assign p_ctx = hhit_reg ? pat_rd_reg : 64'd0;
    assign p_fwd = fhit_reg ? fval_reg   : 64'd0;
    assign p_str = shit_reg ? psum_reg   : 64'd0;

    always_comb
    begin
        if (cc_reg > cf_reg && cc_reg > cs_reg && cc_reg > thr_reg)
        begin
            src  = hlvp_pkg::SRC_CONTEXT;
            pred = p_ctx;
        end
        else if (cf_reg >= cc_reg && cf_reg > cs_reg && cf_reg > thr_reg)
        begin
            src  = hlvp_pkg::SRC_FORWARD;
            pred = p_fwd;
        end
        else
        begin
            src  = hlvp_pkg::SRC_STRIDE;
            pred = p_str;
        end
    end

    assign hptr = hrow_reg[321:320];

    always_comb
    begin
        if (hhit_reg)
        begin
            hrow_new = hrow_reg;
            hrow_new[{hptr, 6'b0} + 9'd64 +: 64] = val_reg;
            hrow_new[321:320] = hptr + 2'd1;
            hslot = hidx_reg;
        end
        else
        begin
            hrow_new = {2'd1, 192'd0, val_reg, pc_reg};
            hslot = hhead_reg;
        end
    end

    assign fslot  = fhit_reg ? fidx_reg : fhead_reg;
    assign sslot  = shit_reg ? sidx_reg : shead_reg;
    assign fwd_we = cmd.load_wr || cmd.store_wr;

    // memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            hist_mem[hslot] <= hrow_new;
        hist_rd_reg <= hist_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fwd_we)
            fwd_mem[fslot] <= {val_reg, addr_reg};
        fwd_rd_reg <= fwd_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            str_mem[sslot] <= shit_reg ? {val_reg - slast_reg, val_reg, pc_reg}
                                       : {64'd0, val_reg, pc_reg};
        str_rd_reg <= str_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
            pat_mem[clr_reg] <= 64'd0;
        else if (cmd.load_wr)
            pat_mem[hash_reg] <= val_reg;
        pat_rd_reg <= pat_mem[hash_reg];
    end

    // valid bits, ring heads, confidence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            fvalid_reg <= '0;
            svalid_reg <= '0;
            hhead_reg  <= '0;
            fhead_reg  <= '0;
            shead_reg  <= '0;
            cc_reg     <= '0;
            cf_reg     <= '0;
            cs_reg     <= '0;
        end
        else
        begin
            // heads are brought below the limit one subtract a cycle during the scan
            if (cmd.scan_en)
            begin
                if ({1'b0, hhead_reg} >= lim)
                    hhead_reg <= hhead_reg - lim[IW-1:0];
                if ({1'b0, fhead_reg} >= lim)
                    fhead_reg <= fhead_reg - lim[IW-1:0];
                if ({1'b0, shead_reg} >= lim)
                    shead_reg <= shead_reg - lim[IW-1:0];
            end
            if (fwd_we)
            begin
                fvalid_reg[fslot] <= 1'b1;
                if (!fhit_reg)
                    fhead_reg <= hlvp_pkg::next_head(fhead_reg, lim);
            end
            if (cmd.load_wr)
            begin
                hvalid_reg[hslot] <= 1'b1;
                svalid_reg[sslot] <= 1'b1;
                if (!hhit_reg)
                    hhead_reg <= hlvp_pkg::next_head(hhead_reg, lim);
                if (!shit_reg)
                    shead_reg <= hlvp_pkg::next_head(shead_reg, lim);
                cc_reg <= hlvp_pkg::conf_step(cc_reg, p_ctx == val_reg, pen_reg);
                cf_reg <= hlvp_pkg::conf_step(cf_reg, p_fwd == val_reg, pen_reg);
                cs_reg <= hlvp_pkg::conf_step(cs_reg, p_str == val_reg, pen_reg);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_wr)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            out_pred_reg <= pred;
            out_src_reg  <= src;
            out_ok_reg   <= (pred == val_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pred_reg;
    assign m_tuser  = {out_ok_reg, out_src_reg};

endmodule

// ----- rtl/hybrid_load_value_predictor.sv -----
// Top level of the hybrid load value predictor.
// Hybrid load value predictor: each load (tuser 0) gets a context, a
// store-to-load and a stride prediction, one of which is chosen by three
// global 4-bit confidence counters and returned with its source and a
// correct flag; a store (tuser 1) only updates the store-to-load table and
// returns nothing. Items are handled one at a time. Each item first scans
// the 256 slots of the three keyed tables, one slot per cycle through the
// tag memories' single read port; that scan sets the rate while the output
// register is free. After reset the block clears the 4096-entry pattern
// table one entry a cycle and takes no item until done; configuration writes
// are taken at any time but should only be issued while the block is idle.
// A finished result waits in an output register, so the next item can be
// taken and worked on while the result is still unread.
module hybrid_load_value_predictor
(
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // instr_pc[63:0], mem_address[127:64], data_value[191:128]
    input  logic [0:0]   s_tuser,   // req_type[0]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // predicted_value[63:0]
    output logic [2:0]   m_tuser,   // chosen_source[1:0], prediction_correct[2]
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index, // 0 table_limit, 1 choose_threshold, 2 miss_penalty
    input  logic [8:0]   cfg_data
);

`include "hybrid_load_value_predictor_assert.svh"

    hlvp_pkg::cmd_t    cmd;
    hlvp_pkg::status_t st;

    // registers are always writable
    assign cfg_ready = 1'b1;

    hlvp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    hlvp_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // one item in flight: no transfer right after a transfer
    `HLVP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    // a result is only written into a free output register
    `HLVP_ASSERT_SAME(a_out_free, cmd.load_wr, !st.out_busy, "result overwrote an unread result")
    // datapath commands are mutually exclusive
    `HLVP_ASSERT_SAME(a_cmd_excl, 1'b1, $onehot0({cmd.clear_en, cmd.scan_en, cmd.hash_en, cmd.load_wr, cmd.store_wr}), "overlapping datapath commands")

endmodule

// ----- tb/sv/hybrid_load_value_predictor_tb.sv -----
// Self-checking testbench for the hybrid load value predictor.
module hybrid_load_value_predictor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // register index that the block does not decode
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // a store, which gives no result, can still be in flight for about
    // one table scan after the last result came out
    localparam int SETTLE_CYCLES = 400;
    // covers the pattern table clear after reset and the longest stall
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_PER_PHASE = 130;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [8:0]   cfg_data;

    hybrid_load_value_predictor u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    typedef struct {
        logic [63:0] value;
        logic [1:0]  source;
        logic        correct;
    } prediction_t;

    // one directed access; has_exp marks a result typed in by hand
    typedef struct {
        logic        is_store;
        logic [63:0] pc;
        logic [63:0] addr;
        logic [63:0] data;
        logic        has_exp;
        logic [63:0] exp_value;
        logic [1:0]  exp_source;
        logic        exp_correct;
    } access_t;

    prediction_t pending_q[$];
    int          err_count;
    // typed-in result that replaces the predictor's for the next load
    logic        use_typed;
    prediction_t typed_r;

    // ---------------------------------------------------------------
    // Predictor state: keyed tables, pattern table, confidence, config
    // ---------------------------------------------------------------
    logic [8:0]  lim_reg;
    logic [3:0]  thr_reg;
    logic [3:0]  pen_reg;

    logic [63:0] hist_tag  [hlvp_pkg::TABLE_ENTRIES];
    logic        hist_vld  [hlvp_pkg::TABLE_ENTRIES];
    logic [63:0] hist_val  [hlvp_pkg::TABLE_ENTRIES][4];
    logic [1:0]  hist_ptr  [hlvp_pkg::TABLE_ENTRIES];
    int          hist_head;
    logic [63:0] pat_tbl   [hlvp_pkg::PAT_ENTRIES];
    logic [63:0] fwd_tag   [hlvp_pkg::TABLE_ENTRIES];
    logic [63:0] fwd_val   [hlvp_pkg::TABLE_ENTRIES];
    logic        fwd_vld   [hlvp_pkg::TABLE_ENTRIES];
    int          fwd_head;
    logic [63:0] str_tag   [hlvp_pkg::TABLE_ENTRIES];
    logic [63:0] str_last  [hlvp_pkg::TABLE_ENTRIES];
    logic [63:0] str_delta [hlvp_pkg::TABLE_ENTRIES];
    logic        str_vld   [hlvp_pkg::TABLE_ENTRIES];
    int          str_head;
    logic [3:0]  conf_ctx;
    logic [3:0]  conf_fwd;
    logic [3:0]  conf_str;

    task automatic clear_predictor();
        lim_reg = 9'd256;
        thr_reg = 4'd3;
        pen_reg = 4'd2;
        for (int i = 0; i < hlvp_pkg::TABLE_ENTRIES; i++)
        begin
            hist_vld[i] = 1'b0;
            fwd_vld[i]  = 1'b0;
            str_vld[i]  = 1'b0;
        end
        for (int i = 0; i < hlvp_pkg::PAT_ENTRIES; i++)
            pat_tbl[i] = '0;
        hist_head = 0;
        fwd_head  = 0;
        str_head  = 0;
        conf_ctx  = '0;
        conf_fwd  = '0;
        conf_str  = '0;
    endtask

    // ring allocation with the effective limit clamped to 1..TABLE_ENTRIES
    function automatic int alloc_slot(inout int head);
        int lim;
        int slot;
        lim = (lim_reg == 0) ? 1 : ((lim_reg > hlvp_pkg::TABLE_ENTRIES) ?
              hlvp_pkg::TABLE_ENTRIES : lim_reg);
        slot = head % lim;
        head = (slot + 1) % lim;
        return slot;
    endfunction

    function automatic logic [15:0] xor_quarters(logic [63:0] v);
        return v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48];
    endfunction

    function automatic logic [3:0] bump_conf(logic [3:0] c, logic hit);
        if (hit)
            return (c == 4'd15) ? c : c + 4'd1;
        return (c > pen_reg) ? c - pen_reg : 4'd0;
    endfunction

    function automatic int find_key(ref logic [63:0] tags[hlvp_pkg::TABLE_ENTRIES],
                                    ref logic vld[hlvp_pkg::TABLE_ENTRIES],
                                    input logic [63:0] key);
        for (int i = 0; i < hlvp_pkg::TABLE_ENTRIES; i++)
            if (vld[i] && tags[i] == key)
                return i;
        return -1;
    endfunction

    task automatic record_store(logic [63:0] addr, logic [63:0] data);
        int s;
        s = find_key(fwd_tag, fwd_vld, addr);
        if (s < 0)
            s = alloc_slot(fwd_head);
        fwd_tag[s] = addr;
        fwd_val[s] = data;
        fwd_vld[s] = 1'b1;
    endtask

    // applies one accepted access; a load queues its predicted result
    task automatic predict_access(logic is_store, logic [63:0] pc,
                                  logic [63:0] addr, logic [63:0] data);
        int          hs;
        int          fs;
        int          ss;
        int          slot;
        logic [31:0] h;
        logic [11:0] hash;
        logic [1:0]  p;
        logic [63:0] p_ctx;
        logic [63:0] p_fwd;
        logic [63:0] p_str;
        prediction_t r;
        if (is_store)
        begin
            record_store(addr, data);
            return;
        end
        p_ctx = '0;
        p_fwd = '0;
        p_str = '0;
        hash  = '0;
        hs = find_key(hist_tag, hist_vld, pc);
        if (hs >= 0)
        begin
            h = '0;
            p = hist_ptr[hs];
            for (int i = 0; i < 4; i++)
            begin
                h = h ^ ({16'd0, xor_quarters(hist_val[hs][p])} << (2 * (3 - i)));
                p = p + 2'd1;
            end
            hash  = h[11:0];
            p_ctx = pat_tbl[hash];
        end
        fs = find_key(fwd_tag, fwd_vld, addr);
        if (fs >= 0)
            p_fwd = fwd_val[fs];
        ss = find_key(str_tag, str_vld, pc);
        if (ss >= 0)
            p_str = str_last[ss] + str_delta[ss];

        if (conf_ctx > conf_fwd && conf_ctx > conf_str && conf_ctx > thr_reg)
        begin
            r.value  = p_ctx;
            r.source = hlvp_pkg::SRC_CONTEXT;
        end
        else if (conf_fwd >= conf_ctx && conf_fwd > conf_str && conf_fwd > thr_reg)
        begin
            r.value  = p_fwd;
            r.source = hlvp_pkg::SRC_FORWARD;
        end
        else
        begin
            r.value  = p_str;
            r.source = hlvp_pkg::SRC_STRIDE;
        end
        r.correct = (r.value == data);
        if (use_typed)
            r = typed_r;
        pending_q = {pending_q, r};

        conf_ctx = bump_conf(conf_ctx, p_ctx == data);
        conf_fwd = bump_conf(conf_fwd, p_fwd == data);
        conf_str = bump_conf(conf_str, p_str == data);

        // pattern table trained at the hash seen before the history moves
        pat_tbl[hash] = data;
        if (hs >= 0)
        begin
            hist_val[hs][hist_ptr[hs]] = data;
            hist_ptr[hs] = hist_ptr[hs] + 2'd1;
        end
        else
        begin
            slot = alloc_slot(hist_head);
            hist_tag[slot]    = pc;
            hist_vld[slot]    = 1'b1;
            hist_val[slot][0] = data;
            for (int i = 1; i < 4; i++)
                hist_val[slot][i] = '0;
            hist_ptr[slot] = 2'd1;
        end
        record_store(addr, data);
        if (ss >= 0)
        begin
            str_delta[ss] = data - str_last[ss];
            str_last[ss]  = data;
        end
        else
        begin
            slot = alloc_slot(str_head);
            str_tag[slot]   = pc;
            str_last[slot]  = data;
            str_delta[slot] = '0;
            str_vld[slot]   = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: stall pattern and field compare
    // ---------------------------------------------------------------
    int stall_mode;
    int stall_left;

    always @(posedge clk)
    begin
        prediction_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with nothing expected: value %h", m_tdata);
                err_count++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (m_tdata !== e.value)
                begin
                    $error("predicted_value expected %h actual %h", e.value, m_tdata);
                    err_count++;
                end
                if (m_tuser[1:0] !== e.source)
                begin
                    $error("chosen_source expected %0d actual %0d", e.source, m_tuser[1:0]);
                    err_count++;
                end
                if (m_tuser[2] !== e.correct)
                begin
                    $error("prediction_correct expected %0b actual %0b",
                           e.correct, m_tuser[2]);
                    err_count++;
                end
            end
        end
        // stall mode is redrawn when its run ends: open, patchy, mostly shut
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 600);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog over cycles with no transfer on any channel
    int idle_cycles;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Sender: bursts of transfers with random gaps
    // ---------------------------------------------------------------
    int burst_left;

    task automatic send_access(logic is_store, logic [63:0] pc,
                               logic [63:0] addr, logic [63:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= is_store;
        s_tdata  <= {data, addr, pc};
        do
            @(posedge clk);
        while (!s_tready);
        predict_access(is_store, pc, addr, data);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // long runs without gaps now and then
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(1, 300);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hlvp_pkg::REG_TABLE_LIMIT: lim_reg = val;
            hlvp_pkg::REG_THRESHOLD:   thr_reg = val[3:0];
            hlvp_pkg::REG_PENALTY:     pen_reg = val[3:0];
            default:                   ;
        endcase
    endtask

    task automatic set_config(logic [8:0] lim, logic [8:0] thr, logic [8:0] pen);
        wait_drained();
        write_reg(hlvp_pkg::REG_TABLE_LIMIT, lim);
        write_reg(hlvp_pkg::REG_THRESHOLD, thr);
        write_reg(hlvp_pkg::REG_PENALTY, pen);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Random access stream: small pc and address pools so tables hit
    // ---------------------------------------------------------------
    logic [63:0] pc_pool    [16];
    logic [63:0] addr_pool  [32];
    logic [63:0] seq_last   [16];
    logic [63:0] seq_step   [16];
    logic [63:0] seq_cycle  [16][3];
    int          seq_pos    [16];
    logic [63:0] last_store [logic [63:0]];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic seed_pools();
        for (int i = 0; i < 16; i++)
        begin
            pc_pool[i]  = (i < 12) ? 64'h4000 + 64'(i * 4) : rand64();
            seq_last[i] = rand64();
            seq_step[i] = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 64));
            seq_pos[i]  = 0;
            for (int j = 0; j < 3; j++)
                seq_cycle[i][j] = ($urandom_range(0, 1) == 1) ? rand64()
                                                              : 64'($urandom_range(0, 9));
        end
        for (int i = 0; i < 32; i++)
            addr_pool[i] = (i < 24) ? 64'h1000_0000 + 64'(i * 8) : rand64();
    endtask

    task automatic send_random(int n_items, int pc_span);
        int          k;
        int          pick;
        logic [63:0] addr;
        logic [63:0] data;
        for (int n = 0; n < n_items; n++)
        begin
            addr = ($urandom_range(0, 19) == 0) ? rand64()
                                                : addr_pool[$urandom_range(0, 31)];
            if ($urandom_range(0, 3) == 0)
            begin
                data = ($urandom_range(0, 1) == 1) ? rand64() : 64'($urandom_range(0, 9));
                last_store[addr] = data;
                send_access(1'b1, rand64(), addr, data);
            end
            else
            begin
                k    = $urandom_range(0, pc_span - 1);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    data = seq_last[k] + seq_step[k];
                else if (pick < 70)
                begin
                    data = seq_cycle[k][seq_pos[k]];
                    seq_pos[k] = (seq_pos[k] + 1) % 3;
                end
                else if (pick < 88 && last_store.exists(addr))
                    data = last_store[addr];
                else
                    data = rand64();
                seq_last[k] = data;
                last_store[addr] = data;
                send_access(1'b0, ($urandom_range(0, 24) == 0) ? rand64() : pc_pool[k],
                            addr, data);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Directed accesses
    // ---------------------------------------------------------------
    localparam logic [63:0] ONES = '1;
    localparam logic [63:0] A0   = 64'h0000_0000_2000_0000;
    localparam logic [63:0] P0   = 64'h0000_0000_0040_0100;

    access_t directed[] = '{
        // cold start: all counters 0, stride chosen, every table misses
        '{1'b0, '0,   '0,   '0,   1'b1, '0, hlvp_pkg::SRC_STRIDE, 1'b1},
        // counters now all 1; stride still chosen, new pc misses
        '{1'b0, ONES, ONES, ONES, 1'b1, '0, hlvp_pkg::SRC_STRIDE, 1'b0},
        '{1'b1, '0,   ONES, 64'h8000_0000_0000_0000, 1'b0, '0, '0, 1'b0},
        '{1'b0, ONES, ONES, 64'h8000_0000_0000_0000, 1'b0, '0, '0, 1'b0},
        '{1'b1, ONES, A0,   64'h1234_5678_9abc_def0, 1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'h1234_5678_9abc_def0, 1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'd10, 1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'd20, 1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'd30, 1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'd40, 1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'd50, 1'b0, '0, '0, 1'b0},
        // stride wraps through zero
        '{1'b0, P0,   A0,   ONES,   1'b0, '0, '0, 1'b0},
        '{1'b0, P0,   A0,   64'd7,  1'b0, '0, '0, 1'b0},
        '{1'b1, '0,   '0,   ONES,   1'b0, '0, '0, 1'b0},
        '{1'b0, 64'h55, '0, ONES,   1'b0, '0, '0, 1'b0},
        '{1'b0, 64'h55, '0, ONES,   1'b0, '0, '0, 1'b0},
        '{1'b0, 64'h55, '0, ONES,   1'b0, '0, '0, 1'b0},
        '{1'b0, 64'h55, '0, ONES,   1'b0, '0, '0, 1'b0}
    };

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = hlvp_pkg::REG_TABLE_LIMIT;
        cfg_data   = '0;
        err_count  = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_left = 0;
        burst_left = 0;
        use_typed  = 1'b0;
        clear_predictor();
        seed_pools();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            // typed-in result stands in for the predictor's
            use_typed = directed[i].has_exp;
            typed_r   = '{directed[i].exp_value, directed[i].exp_source,
                          directed[i].exp_correct};
            send_access(directed[i].is_store, directed[i].pc, directed[i].addr,
                        directed[i].data);
        end
        use_typed = 1'b0;

        send_random(RAND_PER_PHASE, 16);
        // limit 0 acts as 1: every new key evicts; lowest threshold, heavy penalty
        set_config(9'd0, 9'd0, 9'd15);
        send_random(RAND_PER_PHASE, 16);
        // limit above the table size, threshold out of reach, no penalty
        set_config(9'h1FF, 9'd15, 9'd0);
        send_random(RAND_PER_PHASE, 16);
        // small ring shrinks the head under live entries
        set_config(9'd5, 9'd7, 9'd1);
        wait_drained();
        write_reg(REG_UNUSED, 9'h1FF);
        cfg_valid <= 1'b0;
        send_random(RAND_PER_PHASE, 16);
        set_config(9'd1, 9'd1, 9'd4);
        send_random(RAND_PER_PHASE / 2, 4);
        set_config(9'd256, 9'd3, 9'd2);
        send_random(RAND_PER_PHASE, 12);

        wait_drained();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hlvp_pkg.sv
rtl/hlvp_ctrl.sv
rtl/hlvp_datapath.sv
rtl/hybrid_load_value_predictor.sv
tb/sv/hybrid_load_value_predictor_tb.sv
